/* rtl/core/tde_pkg.sv */
// shared types, constants and helper functions of the trajectory derivative engine
// no dependencies
`default_nettype none

package tde_pkg;

  localparam int CMDQ_DEPTH   = 2;
  localparam int CMDQ_AW      = $clog2(CMDQ_DEPTH);
  localparam int RESQ_DEPTH   = 4;
  localparam int RESQ_AW      = $clog2(RESQ_DEPTH);
  localparam int CORDIC_STEPS = 28;
  localparam int SQRT_STEPS   = 32;
  localparam int DIV_W        = 56;
  localparam int DEN_W        = 33;
  localparam int DIV_CW       = $clog2(DIV_W);

  localparam logic signed [33:0] PI_Q28      = 34'sd843314857;
  localparam logic [17:0]        SPEED_SCALE = 18'd256000;
  localparam logic signed [40:0] CURV_SCALE  = 41'sd125;
  localparam logic signed [53:0] ACCEL_SCALE = 54'sd1000000;

  typedef enum logic [3:0] {
    B_IDLE,
    B_SQUARE,
    B_SUM,
    B_SQRT,
    B_NORM,
    B_CORDIC,
    B_SPEED,
    B_CURV,
    B_ACCEL,
    B_EMIT
  } back_state_t;

  // one classified point, handed from front to back
  typedef struct packed {
    logic               single;
    logic               has_prev;
    logic               fin;
    logic signed [32:0] dx;
    logic signed [32:0] dy;
    logic [31:0]        dur;
  } cmd_t;

  typedef struct packed {
    logic [31:0] heading;
    logic [31:0] speed;
    logic [31:0] curvature;
    logic [31:0] accel;
    logic        div_fault;
    logic        run_end;
  } res_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DIV_W-1:0] quo;
  } div_rsp_t;

  // arctan(2^-i) in q0.28
  function automatic logic [27:0] atan_at(input logic [4:0] i);
    logic [27:0] v;
    case (i)
      5'd0:    v = 28'd210828714;
      5'd1:    v = 28'd124459457;
      5'd2:    v = 28'd65760959;
      5'd3:    v = 28'd33381290;
      5'd4:    v = 28'd16755422;
      5'd5:    v = 28'd8385879;
      5'd6:    v = 28'd4193963;
      5'd7:    v = 28'd2097109;
      5'd8:    v = 28'd1048571;
      5'd9:    v = 28'd524287;
      5'd10:   v = 28'd262144;
      5'd11:   v = 28'd131072;
      5'd12:   v = 28'd65536;
      5'd13:   v = 28'd32768;
      5'd14:   v = 28'd16384;
      5'd15:   v = 28'd8192;
      5'd16:   v = 28'd4096;
      5'd17:   v = 28'd2048;
      5'd18:   v = 28'd1024;
      5'd19:   v = 28'd512;
      5'd20:   v = 28'd256;
      5'd21:   v = 28'd128;
      5'd22:   v = 28'd64;
      5'd23:   v = 28'd32;
      5'd24:   v = 28'd16;
      5'd25:   v = 28'd8;
      5'd26:   v = 28'd4;
      5'd27:   v = 28'd2;
      default: v = 28'd0;
    endcase
    return v;
  endfunction

  function automatic logic [31:0] sat_s34(input logic signed [33:0] v);
    logic [31:0] r;
    if (v > 34'sd2147483647) begin
      r = 32'h7fff_ffff;
    end else if (v < -34'sd2147483648) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // sign and magnitude quotient to saturated signed 32 bits
  function automatic logic [31:0] sat_quo_s(input logic neg, input logic [DIV_W-1:0] q);
    logic [31:0] r;
    if (!neg) begin
      r = (q > DIV_W'(32'h7fff_ffff)) ? 32'h7fff_ffff : q[31:0];
    end else begin
      r = (q > DIV_W'(32'h8000_0000)) ? 32'h8000_0000 : 32'(-q[31:0]);
    end
    return r;
  endfunction

  function automatic logic [31:0] sat_quo_u(input logic [DIV_W-1:0] q);
    return (q[DIV_W-1:32] != '0) ? 32'hffff_ffff : q[31:0];
  endfunction

endpackage

`default_nettype wire

/* rtl/core/tde_front.sv */
// front end: takes points, keeps the prior point, forms segment differences
// and classifies each point into a command for the back end; uses tde_pkg
`default_nettype none

module tde_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  output logic               full,
  input  wire logic [31:0]   pos_x,
  input  wire logic [31:0]   pos_y,
  input  wire logic [31:0]   stamp,
  input  wire logic          final_point,
  input  wire logic          cq_full,
  output logic               cq_push,
  output tde_pkg::cmd_t      cq_wr
);
  import tde_pkg::*;

  logic [31:0] prior_x, prior_y, prior_stamp;
  logic [1:0]  points_seen;
  logic        accept;

  assign full   = cq_full;
  assign accept = push && !cq_full;

  always_comb begin
    cq_wr          = '0;
    cq_wr.fin      = final_point;
    cq_wr.has_prev = (points_seen == 2'd2);
    cq_wr.single   = (points_seen == 2'd0);
    cq_wr.dx       = $signed({pos_x[31], pos_x}) - $signed({prior_x[31], prior_x});
    cq_wr.dy       = $signed({pos_y[31], pos_y}) - $signed({prior_y[31], prior_y});
    cq_wr.dur      = stamp - prior_stamp;
    // the first point of a run only loads the prior point, unless it is also the final point
    cq_push        = accept && (points_seen != 2'd0 || final_point);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      points_seen <= 2'd0;
    end else if (accept) begin
      if (final_point) begin
        points_seen <= 2'd0;
      end else if (points_seen == 2'd0) begin
        points_seen <= 2'd1;
      end else begin
        points_seen <= 2'd2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !final_point) begin
      prior_x     <= pos_x;
      prior_y     <= pos_y;
      prior_stamp <= stamp;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/tde_cmdq.sv */
// short command queue between front and back end
// uses tde_pkg
`default_nettype none

module tde_cmdq (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          wr_en,
  input  tde_pkg::cmd_t      wr_data,
  output logic               full,
  input  wire logic          rd_en,
  output tde_pkg::cmd_t      rd_data,
  output logic               empty
);
  import tde_pkg::*;

  cmd_t               entries [CMDQ_DEPTH];
  logic [CMDQ_AW-1:0] wr_ptr, rd_ptr;
  logic [CMDQ_AW:0]   count;

  assign full    = (count == (CMDQ_AW+1)'(CMDQ_DEPTH));
  assign empty   = (count == '0);
  assign rd_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + (CMDQ_AW+1)'(wr_en) - (CMDQ_AW+1)'(rd_en);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entries[wr_ptr] <= wr_data;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/tde_div.sv */
// shared unsigned restoring divider, one quotient bit per cycle
// uses tde_pkg
`default_nettype none

module tde_div (
  input  wire logic          clk,
  input  wire logic          rst,
  input  tde_pkg::div_req_t  req,
  output tde_pkg::div_rsp_t  rsp
);
  import tde_pkg::*;

  logic [DIV_W-1:0]  n;
  logic [DEN_W-1:0]  den;
  logic [DEN_W-1:0]  rem, rem_next;
  logic [DEN_W:0]    rem2;
  logic              qbit;
  logic [DIV_CW-1:0] cnt;
  logic              busy, done;

  always_comb begin
    rem2     = {rem, n[DIV_W-1]};
    qbit     = (rem2 >= {1'b0, den});
    rem_next = qbit ? DEN_W'(rem2 - {1'b0, den}) : rem2[DEN_W-1:0];
    rsp.busy = busy;
    rsp.done = done;
    rsp.quo  = n;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CW'(DIV_W-1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // dividend register shifts out and collects the quotient
  always_ff @(posedge clk) begin
    if (req.start) begin
      n   <= req.num;
      den <= req.den;
      rem <= '0;
    end else if (busy) begin
      n   <= {n[DIV_W-2:0], qbit};
      rem <= rem_next;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/tde_back.sv */
// back end: length by digit-serial square root, heading by iterative cordic,
// speed, curvature and acceleration through the shared divider, result queue
// uses tde_pkg and the tde_div unit instantiated at the top level
`default_nettype none

module tde_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cq_empty,
  input  tde_pkg::cmd_t      cq_rd,
  output logic               cq_pop,
  output tde_pkg::div_req_t  div_req,
  input  tde_pkg::div_rsp_t  div_rsp,
  input  wire logic          pop,
  output logic               empty,
  output tde_pkg::res_t      res
);
  import tde_pkg::*;

  back_state_t state, state_next;
  cmd_t        cmd;

  logic [4:0]          cnt;
  logic                len_ovf;
  logic [47:0]         ax2, ay2;
  logic [63:0]         sq_n;
  logic [35:0]         sq_rem;
  logic [31:0]         sq_root;
  logic signed [43:0]  cx, cy;
  logic [40:0]         mreg;
  logic signed [33:0]  cz;
  logic [31:0]         nl, nhu, nv, curv, acc;
  logic [31:0]         seg_heading, seg_speed, seg_length, seg_duration;
  logic                div_sent;
  logic [1:0]          emit_cnt, emit_total;

  // result queue
  res_t               rq [RESQ_DEPTH];
  logic [RESQ_AW-1:0] rq_wr, rq_rd;
  logic [RESQ_AW:0]   rq_cnt;
  logic               res_full, res_push;
  res_t               res_in;

  // combinational datapath terms
  logic [32:0]        ax, ay;
  logic [48:0]        sq_sum;
  logic [35:0]        rem2, trial;
  logic               root_ge;
  logic signed [43:0] sx, sy;
  logic signed [33:0] atan_s, cz_new;
  logic [49:0]        spd_prod;
  logic signed [32:0] dh, dv;
  logic signed [40:0] cprod;
  logic [40:0]        cmag;
  logic signed [53:0] aprod;
  logic [53:0]        amag;
  logic               nf, is_old, emit_done;
  back_state_t        after_speed, after_len;

  always_comb begin
    ax       = cmd.dx[32] ? 33'(-cmd.dx) : 33'(cmd.dx);
    ay       = cmd.dy[32] ? 33'(-cmd.dy) : 33'(cmd.dy);
    sq_sum   = {1'b0, ax2} + {1'b0, ay2};
    rem2     = {sq_rem[33:0], sq_n[63:62]};
    trial    = {2'b00, sq_root, 2'b01};
    root_ge  = (rem2 >= trial);
    sx       = cx >>> cnt;
    sy       = cy >>> cnt;
    atan_s   = $signed({6'b0, atan_at(cnt)});
    cz_new   = (cy > 44'sd0) ? cz + atan_s : cz - atan_s;
    spd_prod = nl * SPEED_SCALE;
    dh       = $signed({nhu[31], nhu}) - $signed({seg_heading[31], seg_heading});
    cprod    = 41'(dh) * CURV_SCALE;
    cmag     = cprod[40] ? 41'(-cprod) : cprod;
    dv       = $signed({1'b0, nv}) - $signed({1'b0, seg_speed});
    aprod    = 54'(dv) * ACCEL_SCALE;
    amag     = aprod[53] ? 54'(-aprod) : aprod;
    nf       = (nl == '0) || (cmd.dur == '0);
    res_full = (rq_cnt == (RESQ_AW+1)'(RESQ_DEPTH));
    empty    = (rq_cnt == '0);
    res      = rq[rq_rd];
    after_speed = cmd.has_prev ? B_CURV : B_EMIT;
    after_len   = (cmd.dy == '0) ? B_SPEED : B_NORM;
    if (cmd.single) begin
      emit_total = 2'd1;
    end else begin
      emit_total = {cmd.fin, cmd.has_prev};
    end
    emit_done = (emit_cnt == emit_total);
    is_old    = cmd.has_prev && !cmd.single && (emit_cnt == 2'd0);
  end

  // next state and control outputs
  always_comb begin
    state_next = state;
    cq_pop     = 1'b0;
    div_req    = '0;
    res_push   = 1'b0;
    res_in     = '0;
    unique case (state)
      B_IDLE: begin
        if (!cq_empty) begin
          cq_pop     = 1'b1;
          state_next = cq_rd.single ? B_EMIT : B_SQUARE;
        end
      end
      B_SQUARE: begin
        state_next = B_SUM;
      end
      B_SUM: begin
        state_next = (len_ovf || sq_sum[48]) ? after_len : B_SQRT;
      end
      B_SQRT: begin
        if (cnt == 5'(SQRT_STEPS-1)) begin
          state_next = after_len;
        end
      end
      B_NORM: begin
        if (mreg[39]) begin
          state_next = B_CORDIC;
        end
      end
      B_CORDIC: begin
        if (cnt == 5'(CORDIC_STEPS-1)) begin
          state_next = B_SPEED;
        end
      end
      B_SPEED: begin
        div_req.num = {6'b0, spd_prod};
        div_req.den = {1'b0, cmd.dur};
        if (cmd.dur == '0) begin
          state_next = after_speed;
        end else if (!div_sent) begin
          div_req.start = 1'b1;
        end else if (div_rsp.done) begin
          state_next = after_speed;
        end
      end
      B_CURV: begin
        div_req.num = {15'b0, cmag};
        div_req.den = {seg_length, 1'b0};
        if (seg_length == '0) begin
          state_next = B_ACCEL;
        end else if (!div_sent) begin
          div_req.start = 1'b1;
        end else if (div_rsp.done) begin
          state_next = B_ACCEL;
        end
      end
      B_ACCEL: begin
        div_req.num = {2'b0, amag};
        div_req.den = {1'b0, seg_duration};
        if (seg_duration == '0) begin
          state_next = B_EMIT;
        end else if (!div_sent) begin
          div_req.start = 1'b1;
        end else if (div_rsp.done) begin
          state_next = B_EMIT;
        end
      end
      B_EMIT: begin
        if (cmd.single) begin
          res_in.run_end = 1'b1;
        end else if (is_old) begin
          res_in.heading   = seg_heading;
          res_in.speed     = seg_speed;
          res_in.curvature = curv;
          res_in.accel     = acc;
          res_in.div_fault = (seg_length == '0) || (seg_duration == '0);
        end else begin
          res_in.heading   = nhu;
          res_in.speed     = nv;
          res_in.div_fault = nf;
          res_in.run_end   = (emit_cnt == emit_total - 2'd1);
        end
        if (emit_done) begin
          state_next = B_IDLE;
        end else if (!res_full) begin
          res_push = 1'b1;
        end
      end
      default: begin
        state_next = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      div_sent     <= 1'b0;
      emit_cnt     <= 2'd0;
      seg_heading  <= '0;
      seg_speed    <= '0;
      seg_length   <= '0;
      seg_duration <= '0;
    end else begin
      if (div_req.start) begin
        div_sent <= 1'b1;
      end else if (div_rsp.done) begin
        div_sent <= 1'b0;
      end
      if (state == B_EMIT) begin
        if (emit_done) begin
          emit_cnt <= 2'd0;
          if (cmd.single || cmd.fin) begin
            seg_heading  <= '0;
            seg_speed    <= '0;
            seg_length   <= '0;
            seg_duration <= '0;
          end else begin
            seg_heading  <= nhu;
            seg_speed    <= nv;
            seg_length   <= nl;
            seg_duration <= cmd.dur;
          end
        end else if (res_push) begin
          emit_cnt <= emit_cnt + 2'd1;
        end
      end
    end
  end

  // arithmetic registers
  always_ff @(posedge clk) begin
    if (cq_pop) begin
      cmd <= cq_rd;
    end
    unique case (state)
      B_SQUARE: begin
        len_ovf <= (ax[32:24] != '0) || (ay[32:24] != '0);
        ax2     <= ax[23:0] * ax[23:0];
        ay2     <= ay[23:0] * ay[23:0];
        cx      <= {{11{cmd.dx[32]}}, cmd.dx};
        cy      <= {{11{cmd.dy[32]}}, cmd.dy};
        mreg    <= (ax > ay) ? {8'b0, ax} : {8'b0, ay};
      end
      B_SUM: begin
        // horizontal or zero segment keeps this heading
        nhu     <= cmd.dx[32] ? PI_Q28[31:0] : 32'd0;
        nl      <= 32'hffff_ffff;
        sq_n    <= {sq_sum[47:0], 16'b0};
        sq_rem  <= '0;
        sq_root <= '0;
        cnt     <= '0;
      end
      B_SQRT: begin
        sq_n    <= {sq_n[61:0], 2'b00};
        sq_rem  <= root_ge ? 36'(rem2 - trial) : rem2;
        sq_root <= {sq_root[30:0], root_ge};
        cnt     <= cnt + 5'd1;
        if (cnt == 5'(SQRT_STEPS-1)) begin
          nl <= {sq_root[30:0], root_ge};
        end
      end
      B_NORM: begin
        if (mreg[39]) begin
          cnt <= '0;
          if (cx < 44'sd0) begin
            cx <= -cx;
            cy <= -cy;
            cz <= (cmd.dy > 33'sd0) ? PI_Q28 : -PI_Q28;
          end else begin
            cz <= '0;
          end
        end else if (mreg[39:36] == 4'd0) begin
          mreg <= mreg << 4;
          cx   <= cx <<< 4;
          cy   <= cy <<< 4;
        end else begin
          mreg <= mreg << 1;
          cx   <= cx <<< 1;
          cy   <= cy <<< 1;
        end
      end
      B_CORDIC: begin
        if (cy > 44'sd0) begin
          cx <= cx + sy;
          cy <= cy - sx;
        end else begin
          cx <= cx - sy;
          cy <= cy + sx;
        end
        cz  <= cz_new;
        cnt <= cnt + 5'd1;
        if (cnt == 5'(CORDIC_STEPS-1)) begin
          nhu <= sat_s34(cz_new);
        end
      end
      B_SPEED: begin
        if (cmd.dur == '0) begin
          nv <= '0;
        end else if (div_rsp.done) begin
          nv <= sat_quo_u(div_rsp.quo);
        end
      end
      B_CURV: begin
        if (seg_length == '0) begin
          curv <= '0;
        end else if (div_rsp.done) begin
          curv <= sat_quo_s(cprod[40], div_rsp.quo);
        end
      end
      B_ACCEL: begin
        if (seg_duration == '0) begin
          acc <= '0;
        end else if (div_rsp.done) begin
          acc <= sat_quo_s(aprod[53], div_rsp.quo);
        end
      end
      default: begin
      end
    endcase
  end

  // result queue
  always_ff @(posedge clk) begin
    if (rst) begin
      rq_wr  <= '0;
      rq_rd  <= '0;
      rq_cnt <= '0;
    end else begin
      if (res_push) begin
        rq_wr <= rq_wr + 1'b1;
      end
      if (pop && !empty) begin
        rq_rd <= rq_rd + 1'b1;
      end
      rq_cnt <= rq_cnt + (RESQ_AW+1)'(res_push) - (RESQ_AW+1)'(pop && !empty);
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) begin
      rq[rq_wr] <= res_in;
    end
  end

  a_cordic_bound: assert property (@(posedge clk) disable iff (rst)
    state == B_CORDIC |-> cnt < 5'(CORDIC_STEPS))
    else $error("cordic step count out of range");

  a_resq_no_overrun: assert property (@(posedge clk) disable iff (rst)
    res_push |-> !res_full)
    else $error("result queue written while full");

  a_div_start_idle: assert property (@(posedge clk) disable iff (rst)
    div_req.start |-> !div_rsp.busy && !div_sent)
    else $error("divider started while busy");

  a_emit_bound: assert property (@(posedge clk) disable iff (rst)
    state == B_EMIT |-> emit_cnt <= emit_total)
    else $error("more results emitted than the point produces");

endmodule

`default_nettype wire

/* rtl/core/trajectory_derivative_engine_top.sv */
// trajectory derivative engine top: front end, command queue, back end, divider
// a segment's results are emitted when the next point is processed; in the back end a point
// runs the 32-step square root, the normalize shifts and the 28 cordic steps, then up to
// three divisions on the one shared serial divider, and then emits its results, waiting
// while the result queue is full
// throughput: one point per back end pass; the command queue absorbs two points
// reset (rst, synchronous): empties both queues and starts a new trajectory
`default_nettype none

module trajectory_derivative_engine_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic [31:0] pos_x,
  input  wire logic [31:0] pos_y,
  input  wire logic [31:0] stamp,
  input  wire logic        final_point,
  input  wire logic        pop,
  output logic             empty,
  output logic [31:0]      heading,
  output logic [31:0]      speed,
  output logic [31:0]      curvature,
  output logic [31:0]      accel,
  output logic             div_fault,
  output logic             run_end
);
  import tde_pkg::*;

  cmd_t      cq_wr, cq_rd;
  logic      cq_push, cq_full, cq_pop, cq_empty;
  div_req_t  div_req;
  div_rsp_t  div_rsp;
  res_t      res;

  tde_front u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .pos_x       (pos_x),
    .pos_y       (pos_y),
    .stamp       (stamp),
    .final_point (final_point),
    .cq_full     (cq_full),
    .cq_push     (cq_push),
    .cq_wr       (cq_wr)
  );

  tde_cmdq u_cmdq (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (cq_push),
    .wr_data (cq_wr),
    .full    (cq_full),
    .rd_en   (cq_pop),
    .rd_data (cq_rd),
    .empty   (cq_empty)
  );

  tde_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  tde_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cq_empty (cq_empty),
    .cq_rd    (cq_rd),
    .cq_pop   (cq_pop),
    .div_req  (div_req),
    .div_rsp  (div_rsp),
    .pop      (pop),
    .empty    (empty),
    .res      (res)
  );

  assign heading   = res.heading;
  assign speed     = res.speed;
  assign curvature = res.curvature;
  assign accel     = res.accel;
  assign div_fault = res.div_fault;
  assign run_end   = res.run_end;

endmodule

`default_nettype wire
